FILE: sv/sard_pkg.sv
// ----------------------------------------------------------------------------
// sard_pkg
// Shared constants, codes and controller/datapath interface types for the
// slot allocator with reuse delay.
// ----------------------------------------------------------------------------
package sard_pkg;

	// Table geometry
	localparam int SLOTS  = 1024;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);

	// Slot entry: used flag over free time
	localparam int TIME_W = 32;
	localparam int RAM_W  = TIME_W + 1;

	// Grace window after spawn and reuse delay, in ms (one bit wider than time)
	localparam logic [TIME_W:0] GRACE_MS = (TIME_W + 1)'(2000);
	localparam logic [TIME_W:0] REUSE_MS = (TIME_W + 1)'(500);

	// Configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	typedef enum logic {
		REG_FIRST_SLOT  = 1'b0,
		REG_SPAWN_STAMP = 1'b1
	} reg_idx_t;

	// Request kinds
	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_AGED    = 3'd0,
		ST_APPEND  = 3'd1,
		ST_RECENT  = 3'd2,
		ST_FULL    = 3'd3,
		ST_FREED   = 3'd4,
		ST_IGNORED = 3'd5
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic clr_step;
		logic alloc_init;
		logic scan_step;
		logic end_step;
		logic free_rd;
		logic free_chk;
		logic load_out;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic scan_hit;
		logic scan_done;
		logic out_free;
	} stat_t;

endpackage

FILE: sv/sard_ram.sv
// ----------------------------------------------------------------------------
// sard_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sard_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/sard_ctrl.sv
// ----------------------------------------------------------------------------
// sard_ctrl
// Controller of the slot allocator: clearing pass, request sequencing,
// slot scan and result hand-off.
// ----------------------------------------------------------------------------
module sard_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           req_type,
	input  sard_pkg::stat_t stat,
	output sard_pkg::cmd_t  cmd
);
	import sard_pkg::*;

	typedef enum logic [7:0] {
		S_CLEAR    = 8'b0000_0001,
		S_IDLE     = 8'b0000_0010,
		S_FREE_RD  = 8'b0000_0100,
		S_FREE_CHK = 8'b0000_1000,
		S_ALLOC    = 8'b0001_0000,
		S_SCAN     = 8'b0010_0000,
		S_END      = 8'b0100_0000,
		S_RESP     = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = (req_t'(req_type) == REQ_FREE) ? S_FREE_RD : S_ALLOC;
				end
			end
			S_FREE_RD: begin
				cmd.free_rd = 1'b1;
				state_d = S_FREE_CHK;
			end
			S_FREE_CHK: begin
				cmd.free_chk = 1'b1;
				state_d = S_RESP;
			end
			S_ALLOC: begin
				cmd.alloc_init = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_hit) begin
					state_d = S_RESP;
				end else if (stat.scan_done) begin
					state_d = S_END;
				end
			end
			S_END: begin
				cmd.end_step = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: sv/sard_dp.sv
// ----------------------------------------------------------------------------
// sard_dp
// Datapath of the slot allocator: slot table RAM, high-water count, scan
// address and compare logic, result and output registers.
// ----------------------------------------------------------------------------
module sard_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sard_pkg::cmd_t        cmd,
	output sard_pkg::stat_t       stat,
	input  logic [9:0]            first_slot,
	input  logic [31:0]           spawn_stamp,
	input  logic [9:0]            slot_index,
	input  logic [31:0]           now_ms,
	input  logic                  is_event,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [9:0]            slot_out,
	output sard_pkg::status_t     status
);
	import sard_pkg::*;

	// Captured request
	logic [9:0]        req_idx_q;
	logic [TIME_W-1:0] req_now_q;
	logic              req_ev_q;

	// Allocation state
	logic [CNT_W-1:0]  hw_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  addr_q;
	logic [TIME_W:0]   grace_q;
	logic              have_rec_q;
	logic [SLOT_W-1:0] rec_q;
	logic              rd_vld_s1;
	logic [SLOT_W-1:0] rd_addr_s1;

	// Result and output registers
	logic [9:0]        res_slot_q;
	status_t           res_status_q;
	logic              out_valid_q;
	logic [9:0]        out_slot_q;
	status_t           out_status_q;

	// RAM port signals
	logic              we;
	logic [SLOT_W-1:0] waddr;
	logic [RAM_W-1:0]  wdata;
	logic [SLOT_W-1:0] raddr;
	logic [RAM_W-1:0]  rdata;

	// Decode and compare
	logic              ent_used;
	logic [TIME_W-1:0] ent_time;
	logic              aged;
	logic              hit;
	logic              recent_cand;
	logic              issue;
	logic              full;
	logic              free_ok;
	logic [TIME_W-1:0] free_stamp;
	logic [31:0]       fs_w;
	logic [31:0]       hw_w;
	logic [31:0]       cnt_w;
	logic [31:0]       cnt_new;

	sard_ram #(
		.WIDTH(RAM_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Split the entry read last cycle
	assign ent_used = rdata[RAM_W-1];
	assign ent_time = rdata[TIME_W-1:0];

	// Aged test: freed in the grace window or longer ago than the reuse delay
	assign aged = ({1'b0, ent_time} < grace_q) ||
		({1'b0, req_now_q} > ({1'b0, ent_time} + REUSE_MS));
	assign hit         = cmd.scan_step && rd_vld_s1 && !ent_used && aged;
	assign recent_cand = rd_vld_s1 && !ent_used && !aged && !have_rec_q;
	assign issue       = (addr_q < cnt_q);
	assign full        = (32'(cnt_q) >= 32'(SLOTS));

	// Free checks
	assign free_ok    = (32'(req_idx_q) < 32'(SLOTS)) && ent_used;
	assign free_stamp = (req_ev_q || (req_now_q == spawn_stamp)) ? '0 : req_now_q;

	// Raise the count to first_slot, clamp to the table size
	assign fs_w    = 32'(first_slot);
	assign hw_w    = 32'(hw_q);
	assign cnt_w   = (hw_w < fs_w) ? ((fs_w > 32'(SLOTS)) ? 32'(SLOTS) : fs_w) : hw_w;
	assign cnt_new = 32'(cnt_q) + 32'd1;

	// Read address: the freed slot, else the scan pointer
	assign raddr = cmd.free_rd ? SLOT_W'(req_idx_q) : addr_q[SLOT_W-1:0];

	// Write port select
	always_comb begin
		we    = 1'b0;
		waddr = addr_q[SLOT_W-1:0];
		wdata = '0;
		if (cmd.clr_step) begin
			we = 1'b1;
		end else if (hit) begin
			we    = 1'b1;
			waddr = rd_addr_s1;
			wdata = {1'b1, {TIME_W{1'b0}}};
		end else if (cmd.end_step) begin
			if (!full) begin
				we    = 1'b1;
				waddr = cnt_q[SLOT_W-1:0];
				wdata = {1'b1, {TIME_W{1'b0}}};
			end else if (have_rec_q) begin
				we    = 1'b1;
				waddr = rec_q;
				wdata = {1'b1, {TIME_W{1'b0}}};
			end
		end else if (cmd.free_chk && free_ok) begin
			we    = 1'b1;
			waddr = SLOT_W'(req_idx_q);
			wdata = {1'b0, free_stamp};
		end
	end

	// Status to the controller
	assign stat.clr_last  = (32'(addr_q) == 32'(SLOTS - 1));
	assign stat.scan_hit  = hit;
	assign stat.scan_done = !issue && !rd_vld_s1;
	assign stat.out_free  = !out_valid_q || out_ready;

	// Capture request fields
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_idx_q <= slot_index;
			req_now_q <= now_ms;
			req_ev_q  <= is_event;
		end
	end

	// Advance the clear and scan pointer, track the high-water count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q     <= '0;
			hw_q       <= '0;
			rd_vld_s1  <= 1'b0;
			have_rec_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				addr_q <= addr_q + 1'b1;
			end
			if (cmd.alloc_init) begin
				hw_q       <= CNT_W'(cnt_w);
				addr_q     <= (fs_w >= cnt_w) ? CNT_W'(cnt_w) : CNT_W'(fs_w);
				rd_vld_s1  <= 1'b0;
				have_rec_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				rd_vld_s1 <= issue && !hit;
				if (issue) begin
					addr_q <= addr_q + 1'b1;
				end
				if (recent_cand) begin
					have_rec_q <= 1'b1;
				end
			end
			if (cmd.end_step && !full) begin
				hw_q <= CNT_W'(cnt_new);
			end
		end
	end

	// Hold scan payload: count, grace end, first recent slot, read address
	always_ff @(posedge clk) begin
		if (cmd.alloc_init) begin
			cnt_q   <= CNT_W'(cnt_w);
			grace_q <= {1'b0, spawn_stamp} + GRACE_MS;
		end
		if (cmd.scan_step) begin
			rd_addr_s1 <= addr_q[SLOT_W-1:0];
			if (recent_cand) begin
				rec_q <= rd_addr_s1;
			end
		end
	end

	// Form the result
	always_ff @(posedge clk) begin
		if (hit) begin
			res_slot_q   <= 10'(rd_addr_s1);
			res_status_q <= ST_AGED;
		end else if (cmd.end_step) begin
			if (!full) begin
				res_slot_q   <= 10'(cnt_q);
				res_status_q <= ST_APPEND;
			end else if (have_rec_q) begin
				res_slot_q   <= 10'(rec_q);
				res_status_q <= ST_RECENT;
			end else begin
				res_slot_q   <= '0;
				res_status_q <= ST_FULL;
			end
		end else if (cmd.free_chk) begin
			res_slot_q   <= req_idx_q;
			res_status_q <= free_ok ? ST_FREED : ST_IGNORED;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_slot_q   <= res_slot_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign slot_out  = out_slot_q;
	assign status    = out_status_q;

endmodule

FILE: sv/slot_allocator_with_reuse_delay.sv
// ----------------------------------------------------------------------------
// slot_allocator_with_reuse_delay
// Allocates and frees slots of a fixed table, holding a freed slot back for a
// reuse delay unless freed in the grace window after spawn or the table is full.
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------
//  request   | in_valid / in_ready    | req_type, slot_index, now_ms, is_event
//  result    | out_valid / out_ready  | slot_out, status
//  config    | psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
//
//  A free steps through read, check and result states before out_valid rises;
//  an allocate scans any slots from first_slot up to the count, stopping at an
//  aged hit, as the scan walks the table RAM read port one slot per cycle.
//  After reset a clearing pass writes every table entry with in_ready low;
//  configuration writes are taken throughout.
//  A waiting result holds the next request only at its result hand-off.
// ----------------------------------------------------------------------------
module slot_allocator_with_reuse_delay (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sard_pkg::ADDR_W-1:0]  paddr,
	input  logic [sard_pkg::DATA_W-1:0]  pwdata,
	output logic [sard_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         req_type,
	input  logic [9:0]                   slot_index,
	input  logic [31:0]                  now_ms,
	input  logic                         is_event,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [9:0]                   slot_out,
	output logic [2:0]                   status
);
	import sard_pkg::*;

	logic [9:0]  first_slot_q;
	logic [31:0] spawn_stamp_q;
	logic        cfg_wr;
	reg_idx_t    reg_sel;
	cmd_t        cmd;
	stat_t       stat;
	status_t     status_o;

	// Configuration register decode
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_slot_q  <= 10'd1;
			spawn_stamp_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_FIRST_SLOT:  first_slot_q  <= pwdata[9:0];
				REG_SPAWN_STAMP: spawn_stamp_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	// Register read back
	always_comb begin
		unique case (reg_sel)
			REG_FIRST_SLOT:  prdata = DATA_W'(first_slot_q);
			REG_SPAWN_STAMP: prdata = DATA_W'(spawn_stamp_q);
			default:         prdata = '0;
		endcase
	end

	sard_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.stat    (stat),
		.cmd     (cmd)
	);

	sard_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.first_slot (first_slot_q),
		.spawn_stamp(spawn_stamp_q),
		.slot_index (slot_index),
		.now_ms     (now_ms),
		.is_event   (is_event),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.slot_out   (slot_out),
		.status     (status_o)
	);

	assign status = status_o;

endmodule

FILE: sv/sard_checker.sv
// ----------------------------------------------------------------------------
// sard_checker
// Port-level checks for the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module sard_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready,
	input logic        in_valid,
	input logic        in_ready,
	input logic        req_type,
	input logic [9:0]  slot_index,
	input logic [31:0] now_ms,
	input logic        is_event,
	input logic        out_valid,
	input logic        out_ready,
	input logic [9:0]  slot_out,
	input logic [2:0]  status
);
	import sard_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slot_out) && $stable(status))
		else $error("stalled result changed or dropped");

	// One request at a time: the block is busy the cycle after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	// Status codes stay in their defined range
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_IGNORED))
		else $error("undefined status code");

	// Full report carries slot zero
	a_full_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |-> (slot_out == '0))
		else $error("full report with nonzero slot");

	// Configuration port never waits
	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> pready)
		else $error("configuration port stalled");

endmodule

bind slot_allocator_with_reuse_delay sard_checker u_sard_checker (.*);
